[rtl/core/ledpwm_pkg.sv]
`default_nettype none

package ledpwm_pkg;

  localparam int GRB_BITS = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [6:0] MAX_RESET_SLOTS = 7'd64;

  typedef enum logic [2:0] {
    REG_BRIGHTNESS  = 3'd0,
    REG_DUTY_ONE    = 3'd1,
    REG_DUTY_ZERO   = 3'd2,
    REG_SHOW_ALL    = 3'd3,
    REG_RESET_SLOTS = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    COLOR_WHITE  = 3'd0,
    COLOR_RED    = 3'd1,
    COLOR_ORANGE = 3'd2,
    COLOR_YELLOW = 3'd3,
    COLOR_GREEN  = 3'd4,
    COLOR_CYAN   = 3'd5,
    COLOR_BLUE   = 3'd6,
    COLOR_PURPLE = 3'd7
  } color_t;

  typedef enum logic [1:0] {
    RATIO_NONE  = 2'd0,
    RATIO_FULL  = 2'd1,
    RATIO_FIFTH = 2'd2
  } ratio_t;

  typedef enum logic {
    FUNC_LED       = 1'b0,
    FUNC_FRAME_END = 1'b1
  } func_t;

  typedef struct packed {
    ratio_t r;
    ratio_t g;
    ratio_t b;
  } ratios_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] duty_one;
    logic [7:0] duty_zero;
    logic       show_all;
    logic [6:0] reset_slots;
  } cfg_t;

  typedef struct packed {
    logic                is_end;
    logic [GRB_BITS-1:0] grb;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic ratios_t palette(color_t c);
    ratios_t p;
    case (c)
      COLOR_WHITE:  p = '{RATIO_FULL, RATIO_FULL,  RATIO_FULL};
      COLOR_RED:    p = '{RATIO_FULL, RATIO_NONE,  RATIO_NONE};
      COLOR_ORANGE: p = '{RATIO_FULL, RATIO_FIFTH, RATIO_NONE};
      COLOR_YELLOW: p = '{RATIO_FULL, RATIO_FULL,  RATIO_NONE};
      COLOR_GREEN:  p = '{RATIO_NONE, RATIO_FULL,  RATIO_NONE};
      COLOR_CYAN:   p = '{RATIO_NONE, RATIO_FULL,  RATIO_FULL};
      COLOR_BLUE:   p = '{RATIO_NONE, RATIO_NONE,  RATIO_FULL};
      COLOR_PURPLE: p = '{RATIO_FULL, RATIO_NONE,  RATIO_FULL};
      default:      p = '{RATIO_NONE, RATIO_NONE,  RATIO_NONE};
    endcase
    return p;
  endfunction

  // floor(b / 5) as (b * 205) >> 10, exact for 8-bit b
  function automatic logic [7:0] scale(ratio_t r, logic [7:0] b);
    logic [15:0] prod;
    logic [7:0]  res;
    prod = 16'(b) * 16'd205;
    case (r)
      RATIO_FULL:  res = b;
      RATIO_FIFTH: res = {2'b00, prod[15:10]};
      default:     res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ledpwm_front.sv]
`default_nettype none

module ledpwm_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ledpwm_pkg::cfg_t cfg,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [2:0] color_index, [7:3] zero
  input  wire logic             s_tuser,   // [0] func
  input  wire logic             q_full,
  output logic                  q_push,
  output ledpwm_pkg::cmd_t      q_cmd
);
  import ledpwm_pkg::*;

  logic       first_pending;
  logic       first_pending_next;
  logic [2:0] held_color;
  logic [2:0] held_color_next;
  logic [2:0] idx;
  logic [2:0] color;
  ratios_t    rat;
  logic       is_end;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign idx      = s_tdata[2:0];
  assign is_end   = (func_t'(s_tuser) == FUNC_FRAME_END);

  always_comb begin
    first_pending_next = first_pending;
    held_color_next    = held_color;
    if (q_push) begin
      if (is_end) begin
        first_pending_next = 1'b1;
      end else if (first_pending) begin
        first_pending_next = 1'b0;
        held_color_next    = idx;
      end
    end
  end

  always_comb begin
    color = idx;
    if (cfg.show_all && !first_pending) begin
      color = held_color;
    end
    rat          = palette(color_t'(color));
    q_cmd.is_end = is_end;
    q_cmd.grb    = {scale(rat.g, cfg.brightness), scale(rat.r, cfg.brightness),
                    scale(rat.b, cfg.brightness)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      held_color    <= 3'd0;
    end else begin
      first_pending <= first_pending_next;
      held_color    <= held_color_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ledpwm_queue.sv]
`default_nettype none

module ledpwm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ledpwm_pkg::cmd_t wr_cmd,
  input  wire logic             pop,
  output ledpwm_pkg::cmd_t      rd_cmd,
  output ledpwm_pkg::q_stat_t   stat
);
  import ledpwm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;

  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_cmd     = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ledpwm_back.sv]
`default_nettype none

module ledpwm_back #(
  parameter int BITS_PER_LED = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ledpwm_pkg::cfg_t cfg,
  input  wire logic             q_empty,
  input  wire ledpwm_pkg::cmd_t q_cmd,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // [7:0] duty
  output logic                  m_tlast    // last
);
  import ledpwm_pkg::*;

  localparam int MAX_SLOTS = (BITS_PER_LED > 64) ? BITS_PER_LED : 64;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  logic                    busy;
  logic                    busy_next;
  logic                    is_end;
  logic                    is_end_next;
  logic [BITS_PER_LED-1:0] shift;
  logic [BITS_PER_LED-1:0] shift_next;
  logic [CNT_W-1:0]        remain;
  logic [CNT_W-1:0]        remain_next;
  logic                    m_tvalid_next;
  logic [7:0]              m_tdata_next;
  logic                    m_tlast_next;
  logic                    out_free;
  logic [BITS_PER_LED-1:0] word;
  logic [6:0]              n_reset;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = out_free && !busy && !q_empty;
  assign n_reset  = (cfg.reset_slots > MAX_RESET_SLOTS) ? MAX_RESET_SLOTS : cfg.reset_slots;

  always_comb begin
    word = '0;
    word[BITS_PER_LED-1 -: GRB_BITS] = q_cmd.grb;
  end

  always_comb begin
    busy_next     = busy;
    is_end_next   = is_end;
    shift_next    = shift;
    remain_next   = remain;
    m_tvalid_next = m_tvalid;
    m_tdata_next  = m_tdata;
    m_tlast_next  = m_tlast;
    if (out_free) begin
      if (busy) begin
        m_tvalid_next = 1'b1;
        m_tlast_next  = (remain == CNT_W'(1));
        m_tdata_next  = is_end ? 8'd0 :
                        (shift[BITS_PER_LED-1] ? cfg.duty_one : cfg.duty_zero);
        shift_next    = shift << 1;
        remain_next   = remain - 1'b1;
        busy_next     = (remain != CNT_W'(1));
      end else if (!q_empty) begin
        is_end_next = q_cmd.is_end;
        if (q_cmd.is_end) begin
          m_tvalid_next = (n_reset != 7'd0);
          m_tdata_next  = 8'd0;
          m_tlast_next  = (n_reset == 7'd1);
          remain_next   = CNT_W'(n_reset) - 1'b1;
          busy_next     = (n_reset > 7'd1);
        end else begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = word[BITS_PER_LED-1] ? cfg.duty_one : cfg.duty_zero;
          m_tlast_next  = 1'b0;
          shift_next    = word << 1;
          remain_next   = CNT_W'(BITS_PER_LED - 1);
          busy_next     = 1'b1;
        end
      end else begin
        m_tvalid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      busy     <= busy_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    is_end  <= is_end_next;
    shift   <= shift_next;
    remain  <= remain_next;
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
  end

endmodule

`default_nettype wire

[rtl/core/led_color_to_pwm_bits_top.sv]
// an accepted item enters the queue; the output register takes its first slot on the pop
// throughput: an led item gives BITS_PER_LED slots and a frame end min(reset_slots, 64)
// zero slots, one per cycle while m_tready is high; the output register sets the pace
// a two-entry queue decouples input acceptance from slot output
// reset (rst, synchronous): registers to defaults, queue empty, next led starts a frame
`default_nettype none

module led_color_to_pwm_bits_top #(
  parameter int BITS_PER_LED = 24
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [2:0] color_index, [7:3] zero
  input  wire logic       s_tuser,   // [0] func
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] duty
  output logic            m_tlast,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import ledpwm_pkg::*;

  cfg_t    cfg;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness  <= 8'd100;
      cfg.duty_one    <= 8'd50;
      cfg.duty_zero   <= 8'd25;
      cfg.show_all    <= 1'b0;
      cfg.reset_slots <= 7'd43;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BRIGHTNESS:  cfg.brightness  <= cfg_data;
        REG_DUTY_ONE:    cfg.duty_one    <= cfg_data;
        REG_DUTY_ZERO:   cfg.duty_zero   <= cfg_data;
        REG_SHOW_ALL:    cfg.show_all    <= cfg_data[0];
        REG_RESET_SLOTS: cfg.reset_slots <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  ledpwm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ledpwm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (push_cmd),
    .pop    (q_pop),
    .rd_cmd (pop_cmd),
    .stat   (q_stat)
  );

  ledpwm_back #(
    .BITS_PER_LED (BITS_PER_LED)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_stat.empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output valid or input stall after reset");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

endmodule

`default_nettype wire

[tb/tb.sv]
module tb;
  import ledpwm_pkg::*;

  localparam int LED_SLOTS = 24;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    func_t  func;
    color_t color;
    int     gap;
    bit     drain;
  } led_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       last;
  } slot_t;

  bit         clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [2:0] color_index, [7:3] zero
  logic       s_tuser;   // [0] func
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] duty
  logic       m_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  // shadow registers and frame state of the encoder
  logic [7:0] bright;
  logic [7:0] duty_hi;
  logic [7:0] duty_lo;
  logic       repeat_first;
  logic [6:0] tail_slots;
  logic       frame_start;
  color_t     frame_color;

  led_item_t  pend_q[$];
  slot_t      want_slots[$];

  bit         in_took;
  bit         m_took;
  bit         quiet;
  bit         gap_loaded;
  int         gap_cnt;
  int         hold_cnt;
  int         cycles;
  int         slot_no;
  int         errors;

  led_color_to_pwm_bits_top #(
    .BITS_PER_LED(LED_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at slot %0d: %s", slot_no, msg);
    errors++;
  endtask

  // green, red, blue bytes of a palette color at the current brightness
  function automatic logic [23:0] grb_word(color_t c);
    logic [7:0] full;
    logic [7:0] fifth;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    full = bright;
    fifth = bright / 8'd5;
    r = '0;
    g = '0;
    b = '0;
    case (c)
      COLOR_WHITE: begin
        r = full;
        g = full;
        b = full;
      end
      COLOR_RED: r = full;
      COLOR_ORANGE: begin
        r = full;
        g = fifth;
      end
      COLOR_YELLOW: begin
        r = full;
        g = full;
      end
      COLOR_GREEN: g = full;
      COLOR_CYAN: begin
        g = full;
        b = full;
      end
      COLOR_BLUE: b = full;
      COLOR_PURPLE: begin
        r = full;
        b = full;
      end
      default: ;
    endcase
    return {g, r, b};
  endfunction

  task automatic expand_item(func_t f, color_t c);
    logic [23:0] word;
    color_t      pick;
    int          n;
    slot_t       s;
    if (f == FUNC_FRAME_END) begin
      n = (tail_slots > MAX_RESET_SLOTS) ? int'(MAX_RESET_SLOTS) : int'(tail_slots);
      for (int k = 0; k < n; k++) begin
        s.duty = '0;
        s.last = (k == n - 1);
        want_slots.push_back(s);
      end
      frame_start = 1'b1;
    end else begin
      if (frame_start) begin
        frame_color = c;
        frame_start = 1'b0;
      end
      pick = repeat_first ? frame_color : c;
      word = grb_word(pick);
      for (int k = 0; k < LED_SLOTS; k++) begin
        s.duty = (k < 24 && word[23 - k]) ? duty_hi : duty_lo;
        s.last = (k == LED_SLOTS - 1);
        want_slots.push_back(s);
      end
    end
  endtask

  // checker, register shadow and predictor
  always @(posedge clk) begin
    slot_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      in_took <= !rst && s_tvalid && s_tready;
      m_took <= !rst && m_tvalid && m_tready;
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          if (want_slots.size() == 0) begin
            report_mismatch("slot with nothing expected");
          end else begin
            want = want_slots.pop_front();
            if (m_tdata !== want.duty)
              report_mismatch($sformatf("duty %0d, expected %0d", m_tdata, want.duty));
            if (m_tlast !== want.last)
              report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
          end
          slot_no++;
        end
        if (cfg_valid && cfg_ready) begin
          case (cfg_index)
            REG_BRIGHTNESS:  bright = cfg_data;
            REG_DUTY_ONE:    duty_hi = cfg_data;
            REG_DUTY_ZERO:   duty_lo = cfg_data;
            REG_SHOW_ALL:    repeat_first = cfg_data[0];
            REG_RESET_SLOTS: tail_slots = cfg_data[6:0];
            default: ;
          endcase
        end
        if (s_tvalid && s_tready)
          expand_item(func_t'(s_tuser), color_t'(s_tdata[2:0]));
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    led_item_t head;
    logic      send;
    send = s_tvalid && !in_took;
    if (!rst && !send && pend_q.size() != 0) begin
      if (!gap_loaded && (!pend_q[0].drain || want_slots.size() == 0)) begin
        gap_cnt = pend_q[0].gap;
        gap_loaded = 1'b1;
      end
      if (gap_loaded) begin
        if (gap_cnt == 0) begin
          head = pend_q.pop_front();
          s_tdata <= {5'b0, head.color};
          s_tuser <= head.func;
          gap_loaded = 1'b0;
          send = 1'b1;
        end else begin
          gap_cnt--;
        end
      end
    end
    s_tvalid <= send;
  end

  // slot receiver
  always @(negedge clk) begin
    if (m_took)
      hold_cnt = quiet ? 0 : $urandom_range(0, 7);
    if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_item(func_t f, color_t c, bit drain = 1'b0);
    led_item_t it;
    it.func = f;
    it.color = c;
    it.gap = quiet ? 0 : $urandom_range(0, 7);
    it.drain = drain;
    pend_q.push_back(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || s_tvalid || want_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_setup();
    write_reg(REG_BRIGHTNESS, pick_byte());
    write_reg(REG_DUTY_ONE, pick_byte());
    write_reg(REG_DUTY_ZERO, pick_byte());
    write_reg(REG_SHOW_ALL, 8'($urandom));
    write_reg(REG_RESET_SLOTS,
              ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)));
    write_reg(3'($urandom_range(REG_RESET_SLOTS + 1, 2**$bits(cfg_index) - 1)),
              8'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    bright = 8'd100;
    duty_hi = 8'd50;
    duty_lo = 8'd25;
    repeat_first = 1'b0;
    tail_slots = 7'd43;
    frame_start = 1'b1;
    frame_color = COLOR_WHITE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults, whole palette
    for (int c = 0; c < 8; c++)
      push_item(FUNC_LED, color_t'(c));
    push_item(FUNC_FRAME_END, COLOR_PURPLE);
    wait_idle();

    // full scale, show-all, frame end with no slots
    write_reg(REG_BRIGHTNESS, 8'hFF);
    write_reg(REG_DUTY_ONE, 8'hFF);
    write_reg(REG_DUTY_ZERO, 8'h00);
    write_reg(REG_SHOW_ALL, 8'h01);
    write_reg(REG_RESET_SLOTS, 8'h00);
    push_item(FUNC_LED, COLOR_PURPLE);
    push_item(FUNC_LED, COLOR_WHITE);
    push_item(FUNC_LED, COLOR_YELLOW);
    push_item(FUNC_FRAME_END, COLOR_WHITE);
    push_item(FUNC_LED, COLOR_ORANGE);
    wait_idle();

    // brightness 9, duty one at zero, long reset saturating, unused register indexes
    write_reg(REG_BRIGHTNESS, 8'd9);
    write_reg(REG_DUTY_ONE, 8'h00);
    write_reg(REG_DUTY_ZERO, 8'hFF);
    write_reg(REG_SHOW_ALL, 8'h00);
    write_reg(REG_RESET_SLOTS, 8'hFF);
    for (int i = REG_RESET_SLOTS + 1; i < 2**$bits(cfg_index); i++)
      write_reg(3'(i), 8'hA5);
    push_item(FUNC_LED, COLOR_ORANGE);
    push_item(FUNC_FRAME_END, COLOR_BLUE, 1'b1);
    push_item(FUNC_LED, COLOR_BLUE);
    wait_idle();

    // show-all switched on inside an open frame
    write_reg(REG_SHOW_ALL, 8'hFE);
    write_reg(REG_SHOW_ALL, 8'h01);
    write_reg(REG_BRIGHTNESS, 8'd4);
    write_reg(REG_RESET_SLOTS, 8'd64);
    push_item(FUNC_LED, COLOR_WHITE);
    push_item(FUNC_LED, COLOR_RED);
    push_item(FUNC_FRAME_END, COLOR_GREEN);
    wait_idle();

    write_reg(REG_SHOW_ALL, 8'h00);
    write_reg(REG_BRIGHTNESS, 8'd5);
    write_reg(REG_RESET_SLOTS, 8'd65);
    push_item(FUNC_LED, COLOR_ORANGE);
    push_item(FUNC_FRAME_END, COLOR_CYAN);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p == 2);
      random_setup();
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_item(func_t'($urandom_range(0, 5) == 0), color_t'($urandom_range(0, 7)),
                  $urandom_range(0, 40) == 0);
      wait_idle();
    end

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
